### hdl/ptps_pkg.sv
package ptps_pkg;

  localparam int TABLE_SLOTS_DEF = 64;
  localparam logic [2:0] MAX_PRIO = 3'd4;

  typedef enum logic [2:0] {
    REQ_CREATE   = 3'd0,
    REQ_REMOVE   = 3'd1,
    REQ_ENQUEUE  = 3'd2,
    REQ_DISPATCH = 3'd3,
    REQ_BLOCK    = 3'd4,
    REQ_UNBLOCK  = 3'd5,
    REQ_SETPRIO  = 3'd6,
    REQ_STATS    = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_NEW      = 2'd0,
    ST_READY    = 2'd1,
    ST_BLOCKED  = 2'd2,
    ST_FINISHED = 2'd3
  } pstate_t;

  typedef enum logic [3:0] {
    RS_OK          = 4'd0,
    RS_NOT_FOUND   = 4'd1,
    RS_FULL        = 4'd2,
    RS_BAD_PRIO    = 4'd3,
    RS_BLOCKED     = 4'd4,
    RS_EMPTY       = 4'd5,
    RS_NOT_BLOCKED = 4'd6,
    RS_FINISHED    = 4'd7,
    RS_QUEUED      = 4'd8
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // latch request, clear scan results
    logic scan;   // examine slot at scan index, advance
    logic commit; // apply the request using scan results
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
  } stat_t;

endpackage

### hdl/ptps_datapath.sv
module ptps_datapath #(
  parameter int TABLE_SLOTS = ptps_pkg::TABLE_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  ptps_pkg::cmd_t   cmd,
  output ptps_pkg::stat_t  stat,
  input  logic [2:0]       in_req,
  input  logic [15:0]      in_id,
  input  logic [2:0]       in_prio,
  output logic [3:0]       res_status,
  output logic [15:0]      res_id,
  output logic [2:0]       res_prio,
  output logic [6:0]       res_total,
  output logic [15:0]      res_exec,
  output logic [6:0]       res_active,
  output logic [6:0]       res_blocked
);
  localparam int IW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  // per-slot fields held in memories; valid bits in flops
  logic [TABLE_SLOTS-1:0] slot_valid;
  logic [15:0] mem_ident [TABLE_SLOTS];
  logic [2:0]  mem_prio  [TABLE_SLOTS];
  logic [1:0]  mem_state [TABLE_SLOTS];
  logic [31:0] mem_seq   [TABLE_SLOTS];
  logic [2:0]  mem_qprio [TABLE_SLOTS];

  logic [31:0] enqueue_counter;
  logic [15:0] next_ident;
  logic [15:0] dispatched_total;

  logic [2:0]  req;
  logic [15:0] id;
  logic [2:0]  prio;
  logic [IW:0] idx;
  logic        rd_vld;
  logic [IW-1:0] rd_idx;
  logic [15:0] rd_ident;
  logic [2:0]  rd_prio;
  logic [1:0]  rd_state;
  logic [31:0] rd_seq;
  logic [2:0]  rd_qprio;

  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [1:0]    hit_state;
  logic [2:0]    hit_prio;
  logic          fre;
  logic [IW-1:0] fre_idx;
  logic          best;
  logic [IW-1:0] best_idx;
  logic [2:0]    best_qprio;
  logic [31:0]   best_age;
  logic [15:0]   best_ident;
  logic [2:0]    best_prio;
  logic [CW-1:0] cnt_tot, cnt_act, cnt_blk;

  logic [31:0] rd_age;
  logic        rd_ok;
  logic        better;

  assign rd_age = enqueue_counter - rd_seq;
  assign rd_ok  = rd_vld && slot_valid[rd_idx];
  assign better = !best || (rd_qprio < best_qprio) ||
                  (rd_qprio == best_qprio && rd_age > best_age);
  assign stat.scan_done = (idx == (IW+1)'(TABLE_SLOTS)) && !rd_vld;

  function automatic logic [6:0] sat7(input logic [CW-1:0] v);
    if (CW > 7 && v > CW'(127)) return 7'd127;
    return 7'(v);
  endfunction

  function automatic logic in_range_ok();
    return prio <= ptps_pkg::MAX_PRIO;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.scan && idx != (IW+1)'(TABLE_SLOTS)) begin
      rd_idx   <= idx[IW-1:0];
      rd_ident <= mem_ident[idx[IW-1:0]];
      rd_prio  <= mem_prio[idx[IW-1:0]];
      rd_state <= mem_state[idx[IW-1:0]];
      rd_seq   <= mem_seq[idx[IW-1:0]];
      rd_qprio <= mem_qprio[idx[IW-1:0]];
    end
    if (cmd.commit) begin
      case (req)
        ptps_pkg::REQ_CREATE: if (in_range_ok() && fre) begin
          mem_ident[fre_idx] <= next_ident;
          mem_prio[fre_idx]  <= prio;
          mem_state[fre_idx] <= ptps_pkg::ST_NEW;
        end
        ptps_pkg::REQ_ENQUEUE: if (hit && hit_state == ptps_pkg::ST_NEW) begin
          mem_state[hit_idx] <= ptps_pkg::ST_READY;
          mem_seq[hit_idx]   <= enqueue_counter;
          mem_qprio[hit_idx] <= hit_prio;
        end
        ptps_pkg::REQ_DISPATCH: if (best) mem_state[best_idx] <= ptps_pkg::ST_FINISHED;
        ptps_pkg::REQ_BLOCK: if (hit && hit_state != ptps_pkg::ST_FINISHED)
          mem_state[hit_idx] <= ptps_pkg::ST_BLOCKED;
        ptps_pkg::REQ_UNBLOCK: if (hit && hit_state == ptps_pkg::ST_BLOCKED)
          mem_state[hit_idx] <= ptps_pkg::ST_NEW;
        ptps_pkg::REQ_SETPRIO: if (in_range_ok() && hit) mem_prio[hit_idx] <= prio;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid       <= '0;
      enqueue_counter  <= '0;
      next_ident       <= 16'd1;
      dispatched_total <= '0;
      rd_vld           <= 1'b0;
      idx              <= '0;
    end else begin
      if (cmd.load) begin
        req <= in_req; id <= in_id; prio <= in_prio;
        idx <= '0; rd_vld <= 1'b0;
        hit <= 1'b0; fre <= 1'b0; best <= 1'b0;
        cnt_tot <= '0; cnt_act <= '0; cnt_blk <= '0;
      end
      if (cmd.scan) begin
        rd_vld <= idx != (IW+1)'(TABLE_SLOTS);
        if (idx != (IW+1)'(TABLE_SLOTS)) idx <= idx + 1'b1;
        if (rd_vld) begin
          if (!slot_valid[rd_idx] && !fre) begin
            fre <= 1'b1; fre_idx <= rd_idx;
          end
          if (rd_ok) begin
            cnt_tot <= cnt_tot + 1'b1;
            if (rd_state != ptps_pkg::ST_FINISHED) cnt_act <= cnt_act + 1'b1;
            if (rd_state == ptps_pkg::ST_BLOCKED) cnt_blk <= cnt_blk + 1'b1;
            if (!hit && rd_ident == id) begin
              hit <= 1'b1; hit_idx <= rd_idx; hit_state <= rd_state;
              hit_prio <= rd_prio;
            end
            if (rd_state == ptps_pkg::ST_READY && better) begin
              best <= 1'b1; best_idx <= rd_idx; best_qprio <= rd_qprio;
              best_age <= rd_age; best_ident <= rd_ident; best_prio <= rd_prio;
            end
          end
        end
      end
      if (cmd.commit) begin
        res_status  <= ptps_pkg::RS_OK;
        res_id      <= '0;
        res_prio    <= '0;
        res_total   <= '0;
        res_exec    <= '0;
        res_active  <= '0;
        res_blocked <= '0;
        case (req)
          ptps_pkg::REQ_CREATE:
            if (!in_range_ok()) res_status <= ptps_pkg::RS_BAD_PRIO;
            else if (!fre) res_status <= ptps_pkg::RS_FULL;
            else begin
              slot_valid[fre_idx] <= 1'b1;
              res_id <= next_ident;
              next_ident <= next_ident + 16'd1;
            end
          ptps_pkg::REQ_REMOVE:
            if (!hit) res_status <= ptps_pkg::RS_NOT_FOUND;
            else slot_valid[hit_idx] <= 1'b0;
          ptps_pkg::REQ_ENQUEUE:
            if (!hit) res_status <= ptps_pkg::RS_NOT_FOUND;
            else if (hit_state == ptps_pkg::ST_BLOCKED) res_status <= ptps_pkg::RS_BLOCKED;
            else if (hit_state == ptps_pkg::ST_FINISHED) res_status <= ptps_pkg::RS_FINISHED;
            else if (hit_state == ptps_pkg::ST_READY) res_status <= ptps_pkg::RS_QUEUED;
            else enqueue_counter <= enqueue_counter + 32'd1;
          ptps_pkg::REQ_DISPATCH:
            if (!best) res_status <= ptps_pkg::RS_EMPTY;
            else begin
              if (dispatched_total != 16'hFFFF) dispatched_total <= dispatched_total + 16'd1;
              res_id   <= best_ident;
              res_prio <= best_prio;
            end
          ptps_pkg::REQ_BLOCK:
            if (!hit) res_status <= ptps_pkg::RS_NOT_FOUND;
            else if (hit_state == ptps_pkg::ST_FINISHED) res_status <= ptps_pkg::RS_FINISHED;
          ptps_pkg::REQ_UNBLOCK:
            if (!hit) res_status <= ptps_pkg::RS_NOT_FOUND;
            else if (hit_state != ptps_pkg::ST_BLOCKED) res_status <= ptps_pkg::RS_NOT_BLOCKED;
          ptps_pkg::REQ_SETPRIO:
            if (!in_range_ok()) res_status <= ptps_pkg::RS_BAD_PRIO;
            else if (!hit) res_status <= ptps_pkg::RS_NOT_FOUND;
          default: begin
            res_total   <= sat7(cnt_tot);
            res_exec    <= dispatched_total;
            res_active  <= sat7(cnt_act);
            res_blocked <= sat7(cnt_blk);
          end
        endcase
      end
    end
  end
endmodule

### hdl/ptps_ctrl.sv
module ptps_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output ptps_pkg::cmd_t  cmd,
  input  ptps_pkg::stat_t stat
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_OUT} state_t;
  state_t state;

  assign in_ready = state == S_IDLE;
  assign cmd.load   = in_valid && in_ready;
  assign cmd.scan   = state == S_SCAN;
  assign cmd.commit = state == S_COMMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_SCAN;
        S_SCAN: if (stat.scan_done) state <= S_COMMIT;
        S_COMMIT: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: if (out_ready) begin
          state <= S_IDLE;
          out_valid <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/process_table_priority_scheduler.sv
// Process table scheduler: each request (create, remove, enqueue, dispatch,
// block, unblock, set priority, statistics) gives one status beat. A request
// sweeps the whole table once through one read port in the scan state, then
// the commit state registers its result beat. One request is in work at a
// time, so a new request is accepted only once the result beat has been
// taken; a stalled result beat holds off the next request. Dispatch picks the
// lowest queued priority, oldest first.
module process_table_priority_scheduler #(
  parameter int TABLE_SLOTS = ptps_pkg::TABLE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // req_type[2:0], proc_id[18:3], priority_req[21:19]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[3:0], result_id[19:4], result_priority[22:20], total_count[29:23],
  // executed_count[45:30], active_count[52:46], blocked_count[59:53]
  output logic [63:0] m_axis_tdata
);
  ptps_pkg::cmd_t  cmd;
  ptps_pkg::stat_t stat;
  logic [3:0]  st;
  logic [15:0] rid, rex;
  logic [2:0]  rpr;
  logic [6:0]  rt, ra, rb;

  ptps_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd, .stat
  );

  ptps_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_req(s_axis_tdata[2:0]), .in_id(s_axis_tdata[18:3]),
    .in_prio(s_axis_tdata[21:19]),
    .res_status(st), .res_id(rid), .res_prio(rpr), .res_total(rt),
    .res_exec(rex), .res_active(ra), .res_blocked(rb)
  );

  assign m_axis_tdata = {4'd0, rb, ra, rex, rt, rpr, rid, st};

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("accept while result pending");
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_axis_tvalid) else $error("commit without result");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd8) else $error("bad status code");
endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int SLOTS = ptps_pkg::TABLE_SLOTS_DEF;

  typedef struct packed {
    ptps_pkg::status_t status;
    logic [15:0] result_id;
    logic [2:0]  result_priority;
    logic [6:0]  total_count;
    logic [15:0] executed_count;
    logic [6:0]  active_count;
    logic [6:0]  blocked_count;
  } sched_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;

  process_table_priority_scheduler uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // scoreboard copy of the process table
  logic        tbl_valid [SLOTS];
  logic [15:0] tbl_id    [SLOTS];
  logic [2:0]  tbl_prio  [SLOTS];
  ptps_pkg::pstate_t tbl_state [SLOTS];
  logic [31:0] tbl_seq   [SLOTS];
  logic [2:0]  tbl_qprio [SLOTS];
  logic [31:0] enq_count;
  logic [15:0] next_id;
  logic [15:0] done_total;

  sched_result_t expected_status_q[$];
  int errors = 0;
  bit idle_en;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("process_table_priority_scheduler regression: fail");
    $finish;
  end

  function automatic int lookup_slot(logic [15:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [6:0] count_sat(int v);
    return (v > 127) ? 7'd127 : v[6:0];
  endfunction

  function automatic sched_result_t predict_request(ptps_pkg::req_t rq, logic [15:0] id,
                                                    logic [2:0] prio);
    sched_result_t r;
    int s, tot, act, blk;
    r = '0;
    r.status = ptps_pkg::RS_OK;
    s = -1;
    case (rq)
      ptps_pkg::REQ_CREATE: begin
        if (prio > ptps_pkg::MAX_PRIO) r.status = ptps_pkg::RS_BAD_PRIO;
        else begin
          for (int i = 0; i < SLOTS; i++)
            if (!tbl_valid[i] && s < 0) s = i;
          if (s < 0) r.status = ptps_pkg::RS_FULL;
          else begin
            tbl_valid[s] = 1'b1;
            tbl_id[s] = next_id;
            tbl_prio[s] = prio;
            tbl_state[s] = ptps_pkg::ST_NEW;
            r.result_id = next_id;
            next_id = next_id + 16'd1;
          end
        end
      end
      ptps_pkg::REQ_REMOVE: begin
        s = lookup_slot(id);
        if (s < 0) r.status = ptps_pkg::RS_NOT_FOUND;
        else tbl_valid[s] = 1'b0;
      end
      ptps_pkg::REQ_ENQUEUE: begin
        s = lookup_slot(id);
        if (s < 0) r.status = ptps_pkg::RS_NOT_FOUND;
        else if (tbl_state[s] == ptps_pkg::ST_BLOCKED) r.status = ptps_pkg::RS_BLOCKED;
        else if (tbl_state[s] == ptps_pkg::ST_FINISHED) r.status = ptps_pkg::RS_FINISHED;
        else if (tbl_state[s] == ptps_pkg::ST_READY) r.status = ptps_pkg::RS_QUEUED;
        else begin
          tbl_state[s] = ptps_pkg::ST_READY;
          tbl_seq[s] = enq_count;
          tbl_qprio[s] = tbl_prio[s];
          enq_count = enq_count + 32'd1;
        end
      end
      ptps_pkg::REQ_DISPATCH: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!tbl_valid[i] || tbl_state[i] != ptps_pkg::ST_READY) continue;
          if (s < 0 || tbl_qprio[i] < tbl_qprio[s] ||
              (tbl_qprio[i] == tbl_qprio[s] &&
               (enq_count - tbl_seq[i]) > (enq_count - tbl_seq[s])))
            s = i;
        end
        if (s < 0) r.status = ptps_pkg::RS_EMPTY;
        else begin
          tbl_state[s] = ptps_pkg::ST_FINISHED;
          if (done_total != 16'hFFFF) done_total = done_total + 16'd1;
          r.result_id = tbl_id[s];
          r.result_priority = tbl_prio[s];
        end
      end
      ptps_pkg::REQ_BLOCK: begin
        s = lookup_slot(id);
        if (s < 0) r.status = ptps_pkg::RS_NOT_FOUND;
        else if (tbl_state[s] == ptps_pkg::ST_FINISHED) r.status = ptps_pkg::RS_FINISHED;
        else tbl_state[s] = ptps_pkg::ST_BLOCKED;
      end
      ptps_pkg::REQ_UNBLOCK: begin
        s = lookup_slot(id);
        if (s < 0) r.status = ptps_pkg::RS_NOT_FOUND;
        else if (tbl_state[s] != ptps_pkg::ST_BLOCKED) r.status = ptps_pkg::RS_NOT_BLOCKED;
        else tbl_state[s] = ptps_pkg::ST_NEW;
      end
      ptps_pkg::REQ_SETPRIO: begin
        if (prio > ptps_pkg::MAX_PRIO) r.status = ptps_pkg::RS_BAD_PRIO;
        else begin
          s = lookup_slot(id);
          if (s < 0) r.status = ptps_pkg::RS_NOT_FOUND;
          else tbl_prio[s] = prio;
        end
      end
      default: begin
        tot = 0; act = 0; blk = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!tbl_valid[i]) continue;
          tot++;
          if (tbl_state[i] != ptps_pkg::ST_FINISHED) act++;
          if (tbl_state[i] == ptps_pkg::ST_BLOCKED) blk++;
        end
        r.total_count = count_sat(tot);
        r.executed_count = done_total;
        r.active_count = count_sat(act);
        r.blocked_count = count_sat(blk);
      end
    endcase
    return r;
  endfunction

  function automatic sched_result_t unpack_beat(logic [63:0] d);
    sched_result_t r;
    r.status          = ptps_pkg::status_t'(d[3:0]);
    r.result_id       = d[19:4];
    r.result_priority = d[22:20];
    r.total_count     = d[29:23];
    r.executed_count  = d[45:30];
    r.active_count    = d[52:46];
    r.blocked_count   = d[59:53];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  // output side: random stall while idle_en is set, check each beat
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !idle_en || ($urandom_range(99) >= 24);
      if (m_axis_tvalid && m_axis_tready) begin
        sched_result_t got, want;
        got = unpack_beat(m_axis_tdata);
        if (expected_status_q.size() == 0) begin
          report_mismatch("unexpected beat", 16'(got.status), 16'd0);
        end else begin
          want = expected_status_q.pop_front();
          if (got.status != want.status)
            report_mismatch("status", 16'(got.status), 16'(want.status));
          if (got.result_id != want.result_id)
            report_mismatch("result_id", got.result_id, want.result_id);
          if (got.result_priority != want.result_priority)
            report_mismatch("result_priority", 16'(got.result_priority),
                            16'(want.result_priority));
          if (got.total_count != want.total_count)
            report_mismatch("total_count", 16'(got.total_count), 16'(want.total_count));
          if (got.executed_count != want.executed_count)
            report_mismatch("executed_count", got.executed_count, want.executed_count);
          if (got.active_count != want.active_count)
            report_mismatch("active_count", 16'(got.active_count), 16'(want.active_count));
          if (got.blocked_count != want.blocked_count)
            report_mismatch("blocked_count", 16'(got.blocked_count),
                            16'(want.blocked_count));
        end
      end
    end
  end

  task automatic send_request(ptps_pkg::req_t rq, logic [15:0] id, logic [2:0] prio);
    while (idle_en && $urandom_range(99) < 24) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, prio, id, rq};
    expected_status_q.push_back(predict_request(rq, id, prio));
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // id of a random live entry, or a random id
  function automatic logic [15:0] pick_id();
    int s;
    if ($urandom_range(9) < 8) begin
      for (int k = 0; k < 8; k++) begin
        s = int'($urandom_range(SLOTS - 1));
        if (tbl_valid[s]) return tbl_id[s];
      end
    end
    return 16'($urandom);
  endfunction

  task automatic test_directed();
    send_request(ptps_pkg::REQ_DISPATCH, 16'h0, 3'd0);
    send_request(ptps_pkg::REQ_STATS, 16'hFFFF, 3'd7);
    send_request(ptps_pkg::REQ_CREATE, 16'h0, 3'd5);
    send_request(ptps_pkg::REQ_CREATE, 16'hFFFF, 3'd4);
    send_request(ptps_pkg::REQ_CREATE, 16'h0, 3'd0);
    send_request(ptps_pkg::REQ_CREATE, 16'h0, 3'd4);
    send_request(ptps_pkg::REQ_REMOVE, 16'hFFFF, 3'd0);
    send_request(ptps_pkg::REQ_ENQUEUE, 16'd1, 3'd0);
    send_request(ptps_pkg::REQ_ENQUEUE, 16'd1, 3'd0);
    send_request(ptps_pkg::REQ_ENQUEUE, 16'd3, 3'd0);
    send_request(ptps_pkg::REQ_ENQUEUE, 16'd2, 3'd0);
    send_request(ptps_pkg::REQ_SETPRIO, 16'd2, 3'd7);
    send_request(ptps_pkg::REQ_SETPRIO, 16'd2, 3'd3);
    send_request(ptps_pkg::REQ_UNBLOCK, 16'd3, 3'd0);
    send_request(ptps_pkg::REQ_BLOCK, 16'd3, 3'd0);
    send_request(ptps_pkg::REQ_BLOCK, 16'd3, 3'd0);
    send_request(ptps_pkg::REQ_ENQUEUE, 16'd3, 3'd0);
    send_request(ptps_pkg::REQ_STATS, 16'd0, 3'd0);
    send_request(ptps_pkg::REQ_DISPATCH, 16'd0, 3'd0);
    send_request(ptps_pkg::REQ_DISPATCH, 16'd0, 3'd0);
    send_request(ptps_pkg::REQ_DISPATCH, 16'd0, 3'd0);
    send_request(ptps_pkg::REQ_BLOCK, 16'd2, 3'd0);
    send_request(ptps_pkg::REQ_ENQUEUE, 16'd2, 3'd0);
    send_request(ptps_pkg::REQ_UNBLOCK, 16'd3, 3'd0);
    send_request(ptps_pkg::REQ_REMOVE, 16'd2, 3'd0);
  endtask

  // fill to full, then drain
  task automatic test_table_full();
    for (int i = 0; i < SLOTS + 2; i++)
      send_request(ptps_pkg::REQ_CREATE, 16'($urandom), 3'($urandom_range(4)));
    send_request(ptps_pkg::REQ_STATS, 16'd0, 3'd0);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i]) send_request(ptps_pkg::REQ_REMOVE, tbl_id[i], 3'd0);
  endtask

  task automatic test_random_mix(int n);
    int sel;
    ptps_pkg::req_t rq;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (sel < 18) rq = ptps_pkg::REQ_CREATE;
      else if (sel < 26) rq = ptps_pkg::REQ_REMOVE;
      else if (sel < 48) rq = ptps_pkg::REQ_ENQUEUE;
      else if (sel < 64) rq = ptps_pkg::REQ_DISPATCH;
      else if (sel < 74) rq = ptps_pkg::REQ_BLOCK;
      else if (sel < 82) rq = ptps_pkg::REQ_UNBLOCK;
      else if (sel < 92) rq = ptps_pkg::REQ_SETPRIO;
      else rq = ptps_pkg::REQ_STATS;
      send_request(rq, pick_id(),
                   ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(4)));
    end
  endtask

  // create/remove pairs: ids keep advancing while the freed slot is reused
  task automatic test_id_advance();
    for (int k = 0; k < 8; k++) begin
      send_request(ptps_pkg::REQ_CREATE, 16'd0, 3'd2);
      send_request(ptps_pkg::REQ_REMOVE, next_id - 16'd1, 3'd0);
    end
    send_request(ptps_pkg::REQ_CREATE, 16'd0, 3'd1);
    send_request(ptps_pkg::REQ_CREATE, 16'd0, 3'd1);
    send_request(ptps_pkg::REQ_CREATE, 16'd0, 3'd1);
    send_request(ptps_pkg::REQ_ENQUEUE, 16'd0, 3'd0);
    send_request(ptps_pkg::REQ_DISPATCH, 16'd0, 3'd0);
  endtask

  initial begin
    int wait_cnt;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    idle_en = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0; tbl_id[i] = '0; tbl_prio[i] = '0;
      tbl_state[i] = ptps_pkg::ST_NEW; tbl_seq[i] = '0; tbl_qprio[i] = '0;
    end
    enq_count = '0;
    next_id = 16'd1;
    done_total = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    idle_en = 1'b1;
    test_table_full();
    test_random_mix(300);
    idle_en = 1'b0;
    test_random_mix(120);
    idle_en = 1'b1;
    test_id_advance();
    test_random_mix(150);

    wait_cnt = 0;
    while (expected_status_q.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_status_q.size() == 0)
      $display("process_table_priority_scheduler regression: pass");
    else
      $display("process_table_priority_scheduler regression: fail");
    $finish;
  end

endmodule

### files.f
hdl/ptps_pkg.sv
hdl/ptps_datapath.sv
hdl/ptps_ctrl.sv
hdl/process_table_priority_scheduler.sv
tb/tb.sv
